// ----- design/ldnem_pkg.sv -----
// Shared types, constants and register codes of the L*a*b*-depth edge map.
package ldnem_pkg;

    localparam int CHAN_W        = 8;
    localparam int IMAGE_WIDTH_W = 11;
    localparam int WEIGHT_W      = 4;
    localparam int GAIN_W        = 5;
    localparam int BRIGHT_W      = 8;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 11;
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [IMAGE_WIDTH_W-1:0] RST_IMAGE_WIDTH = 11'd640;
    localparam logic [WEIGHT_W-1:0]      RST_WEIGHT_L    = 4'd1;
    localparam logic [WEIGHT_W-1:0]      RST_WEIGHT_A    = 4'd1;
    localparam logic [WEIGHT_W-1:0]      RST_WEIGHT_B    = 4'd1;
    localparam logic [WEIGHT_W-1:0]      RST_WEIGHT_D    = 4'd2;
    localparam logic [GAIN_W-1:0]        RST_GAIN        = 5'd10;
    localparam logic [BRIGHT_W-1:0]      RST_BRIGHTNESS  = 8'd1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH = 3'd0,
        CFG_WEIGHT_L    = 3'd1,
        CFG_WEIGHT_A    = 3'd2,
        CFG_WEIGHT_B    = 3'd3,
        CFG_WEIGHT_D    = 3'd4,
        CFG_GAIN        = 3'd5,
        CFG_BRIGHTNESS  = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [CHAN_W-1:0] depth;
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] a;
        logic [CHAN_W-1:0] l;
    } pixel_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight_l;
        logic [WEIGHT_W-1:0] weight_a;
        logic [WEIGHT_W-1:0] weight_b;
        logic [WEIGHT_W-1:0] weight_d;
        logic [GAIN_W-1:0]   gain;
        logic [BRIGHT_W-1:0] brightness;
    } dist_cfg_t;

    typedef struct packed {
        pixel_t pix;
        pixel_t up;
        pixel_t left;
        logic   use_up;
        logic   use_left;
    } job_t;

endpackage

// ----- design/ldnem_front.sv -----
// Front end: accepts pixels, tracks raster position, keeps the line store and left pixel.
module ldnem_front #(
    parameter int MAX_WIDTH = ldnem_pkg::DEF_MAX_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [ldnem_pkg::IMAGE_WIDTH_W-1:0]  image_width,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  ldnem_pkg::pixel_t                    in_pix,
    input  logic                                 frame_start,
    output logic                                 push,
    output ldnem_pkg::job_t                      push_job,
    input  logic                                 q_full
);
    import ldnem_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = (AW + 1 > IMAGE_WIDTH_W) ? AW + 1 : IMAGE_WIDTH_W;

    pixel_t          line_mem [MAX_WIDTH];
    pixel_t          up_rd_reg;
    pixel_t          pix_reg;
    pixel_t          left_job_reg;
    logic            use_up_reg;
    logic            use_left_reg;
    logic            stage_valid_reg;
    logic            stage_valid_next;
    pixel_t          left_pixel_reg;
    logic [AW-1:0]   column_reg;
    logic [AW-1:0]   column_next;
    logic            first_row_reg;
    logic            first_row_next;

    logic            accept;
    logic [AW-1:0]   col_eff;
    logic            first_eff;
    logic [CW-1:0]   width_ext;
    logic [CW-1:0]   width_eff;
    logic [CW-1:0]   col_inc;
    logic            row_end;

    assign push     = stage_valid_reg && !q_full;
    assign in_stall = stage_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;

    assign push_job.pix      = pix_reg;
    assign push_job.up       = up_rd_reg;
    assign push_job.left     = left_job_reg;
    assign push_job.use_up   = use_up_reg;
    assign push_job.use_left = use_left_reg;

    always_comb
    begin
        col_eff   = frame_start ? '0 : column_reg;
        first_eff = frame_start ? 1'b1 : first_row_reg;
        width_ext = CW'(image_width);
        if (width_ext == '0)
        begin
            width_eff = CW'(1);
        end
        else if (width_ext > CW'(MAX_WIDTH))
        begin
            width_eff = CW'(MAX_WIDTH);
        end
        else
        begin
            width_eff = width_ext;
        end
        col_inc = CW'(col_eff) + CW'(1);
        row_end = (col_inc >= width_eff);

        column_next      = column_reg;
        first_row_next   = first_row_reg;
        stage_valid_next = stage_valid_reg;
        if (push)
        begin
            stage_valid_next = 1'b0;
        end
        if (accept)
        begin
            stage_valid_next = 1'b1;
            if (row_end)
            begin
                column_next    = '0;
                first_row_next = 1'b0;
            end
            else
            begin
                column_next    = col_inc[AW-1:0];
                first_row_next = first_eff;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            up_rd_reg         <= line_mem[col_eff];
            line_mem[col_eff] <= in_pix;
            pix_reg           <= in_pix;
            left_job_reg      <= left_pixel_reg;
            use_up_reg        <= !first_eff;
            use_left_reg      <= (col_eff != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            column_reg      <= '0;
            first_row_reg   <= 1'b1;
            left_pixel_reg  <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            column_reg      <= column_next;
            first_row_reg   <= first_row_next;
            if (accept)
            begin
                left_pixel_reg <= in_pix;
            end
        end
    end

endmodule

// ----- design/ldnem_queue.sv -----
// Short job queue between the front end and the distance engine.
module ldnem_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ldnem_pkg::job_t  push_job,
    output logic             full,
    input  logic             pop,
    output ldnem_pkg::job_t  pop_job,
    output logic             empty
);
    import ldnem_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    job_t            slots [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [NW-1:0]   count_reg;

    assign full    = (count_reg == NW'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = slots[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + NW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

endmodule

// ----- design/ldnem_back.sv -----
// Distance engine: weighted distances, bit-serial square root, minimum and brightness.
module ldnem_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ldnem_pkg::dist_cfg_t             dist_cfg,
    input  logic                             q_empty,
    input  ldnem_pkg::job_t                  pop_job,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [ldnem_pkg::CHAN_W-1:0]     edge_strength
);
    import ldnem_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_WSUM,
        S_SCALE,
        S_ROOT,
        S_PRODUCT,
        S_EMIT
    } state_t;

    state_t          state_reg;
    job_t            job_reg;
    logic            nb_left_reg;
    logic [15:0]     sq_reg [4];
    logic [21:0]     sum_reg;
    logic [31:0]     v_reg;
    logic [9:0]      gsq_reg;
    logic [7:0]      root_reg;
    logic [2:0]      bit_reg;
    logic [7:0]      best_reg;
    logic            have_reg;
    logic [15:0]     prod_reg;
    logic            out_valid_reg;
    logic [7:0]      edge_reg;

    pixel_t          nb;
    logic [7:0]      trial;
    logic [15:0]     trial_sq;
    logic [7:0]      root_step;
    logic [7:0]      nb_dist;
    logic [7:0]      best_new;
    logic            out_free;

    function automatic logic [15:0] sq_diff(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] d;
        d = (x > y) ? x - y : y - x;
        return 16'(d) * 16'(d);
    endfunction

    assign pop           = (state_reg == S_IDLE) && !q_empty;
    assign out_valid     = out_valid_reg;
    assign edge_strength = edge_reg;
    assign out_free      = !out_valid_reg || !out_stall;

    always_comb
    begin
        nb        = nb_left_reg ? job_reg.left : job_reg.up;
        trial     = root_reg | (8'd1 << bit_reg);
        trial_sq  = 16'(trial) * 16'(trial);
        root_step = (trial_sq <= v_reg[15:0]) ? trial : root_reg;
        nb_dist   = (v_reg[31:16] != '0) ? 8'hFF : root_step;
        best_new  = (!have_reg || nb_dist < best_reg) ? nb_dist : best_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            job_reg       <= '0;
            nb_left_reg   <= 1'b0;
            sq_reg        <= '{default: '0};
            sum_reg       <= '0;
            v_reg         <= '0;
            gsq_reg       <= '0;
            root_reg      <= '0;
            bit_reg       <= '0;
            best_reg      <= '0;
            have_reg      <= 1'b0;
            prod_reg      <= '0;
            out_valid_reg <= 1'b0;
            edge_reg      <= '0;
        end
        else
        begin
            gsq_reg <= 10'(dist_cfg.gain) * 10'(dist_cfg.gain);
            if (out_valid_reg && !out_stall && state_reg != S_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        job_reg  <= pop_job;
                        have_reg <= 1'b0;
                        best_reg <= '0;
                        if (pop_job.use_up)
                        begin
                            nb_left_reg <= 1'b0;
                            state_reg   <= S_SQUARE;
                        end
                        else if (pop_job.use_left)
                        begin
                            nb_left_reg <= 1'b1;
                            state_reg   <= S_SQUARE;
                        end
                        else
                        begin
                            state_reg <= S_PRODUCT;
                        end
                    end
                end
                S_SQUARE:
                begin
                    sq_reg[0] <= sq_diff(job_reg.pix.l, nb.l);
                    sq_reg[1] <= sq_diff(job_reg.pix.a, nb.a);
                    sq_reg[2] <= sq_diff(job_reg.pix.b, nb.b);
                    sq_reg[3] <= sq_diff(job_reg.pix.depth, nb.depth);
                    state_reg <= S_WSUM;
                end
                S_WSUM:
                begin
                    sum_reg <= 22'(20'(dist_cfg.weight_l) * 20'(sq_reg[0]))
                             + 22'(20'(dist_cfg.weight_a) * 20'(sq_reg[1]))
                             + 22'(20'(dist_cfg.weight_b) * 20'(sq_reg[2]))
                             + 22'(20'(dist_cfg.weight_d) * 20'(sq_reg[3]));
                    state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    v_reg     <= 32'(gsq_reg) * 32'(sum_reg);
                    root_reg  <= '0;
                    bit_reg   <= 3'd7;
                    state_reg <= S_ROOT;
                end
                S_ROOT:
                begin
                    root_reg <= root_step;
                    if (bit_reg == '0)
                    begin
                        best_reg <= best_new;
                        have_reg <= 1'b1;
                        if (!nb_left_reg && job_reg.use_left)
                        begin
                            nb_left_reg <= 1'b1;
                            state_reg   <= S_SQUARE;
                        end
                        else
                        begin
                            state_reg <= S_PRODUCT;
                        end
                    end
                    else
                    begin
                        bit_reg <= bit_reg - 3'd1;
                    end
                end
                S_PRODUCT:
                begin
                    prod_reg  <= 16'(best_reg) * 16'(dist_cfg.brightness);
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        edge_reg      <= (prod_reg > 16'd255) ? 8'hFF : prod_reg[7:0];
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- design/lab_depth_neighbor_edge_map_unit.sv -----
// Top level of the L*a*b*-depth neighbor edge map with its configuration registers.
//
//   Channel   Direction  Handshake           Payload
//   in        sink       in_valid/in_stall   lightness, a_axis, b_axis, depth_value, frame_start
//   out       source     out_valid/out_stall edge_strength
//   cfg       sink       cfg_write           cfg_index, cfg_data
//
// In the distance engine an item with no neighbor goes straight to the product and emit
// states, and each neighbor adds the square, weighted-sum, scale and bit-serial root states.
// The front end takes an item each cycle into a four-entry queue and stalls when it fills.
// Reset is asynchronous; the line store is not cleared and needs no clearing pass.
// The output register holds a finished item while out_stall is high.
module lab_depth_neighbor_edge_map_unit #(
    parameter int MAX_WIDTH = ldnem_pkg::DEF_MAX_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [ldnem_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ldnem_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [ldnem_pkg::CHAN_W-1:0]         lightness,
    input  logic [ldnem_pkg::CHAN_W-1:0]         a_axis,
    input  logic [ldnem_pkg::CHAN_W-1:0]         b_axis,
    input  logic [ldnem_pkg::CHAN_W-1:0]         depth_value,
    input  logic                                 frame_start,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [ldnem_pkg::CHAN_W-1:0]         edge_strength
);
    import ldnem_pkg::*;

    logic [IMAGE_WIDTH_W-1:0] image_width_reg;
    dist_cfg_t                dist_cfg_reg;
    pixel_t                   in_pix;
    logic                     q_push;
    job_t                     q_push_job;
    logic                     q_full;
    logic                     q_pop;
    job_t                     q_pop_job;
    logic                     q_empty;

    assign in_pix.l     = lightness;
    assign in_pix.a     = a_axis;
    assign in_pix.b     = b_axis;
    assign in_pix.depth = depth_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg         <= RST_IMAGE_WIDTH;
            dist_cfg_reg.weight_l   <= RST_WEIGHT_L;
            dist_cfg_reg.weight_a   <= RST_WEIGHT_A;
            dist_cfg_reg.weight_b   <= RST_WEIGHT_B;
            dist_cfg_reg.weight_d   <= RST_WEIGHT_D;
            dist_cfg_reg.gain       <= RST_GAIN;
            dist_cfg_reg.brightness <= RST_BRIGHTNESS;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH: image_width_reg         <= cfg_data;
                CFG_WEIGHT_L:    dist_cfg_reg.weight_l   <= cfg_data[WEIGHT_W-1:0];
                CFG_WEIGHT_A:    dist_cfg_reg.weight_a   <= cfg_data[WEIGHT_W-1:0];
                CFG_WEIGHT_B:    dist_cfg_reg.weight_b   <= cfg_data[WEIGHT_W-1:0];
                CFG_WEIGHT_D:    dist_cfg_reg.weight_d   <= cfg_data[WEIGHT_W-1:0];
                CFG_GAIN:        dist_cfg_reg.gain       <= cfg_data[GAIN_W-1:0];
                CFG_BRIGHTNESS:  dist_cfg_reg.brightness <= cfg_data[BRIGHT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    ldnem_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .image_width (image_width_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_pix      (in_pix),
        .frame_start (frame_start),
        .push        (q_push),
        .push_job    (q_push_job),
        .q_full      (q_full)
    );

    ldnem_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (q_pop_job),
        .empty    (q_empty)
    );

    ldnem_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .dist_cfg      (dist_cfg_reg),
        .q_empty       (q_empty),
        .pop_job       (q_pop_job),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .edge_strength (edge_strength)
    );

    // The queue is never written when full nor read when empty.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue read while empty");

    // A front end that stalls the input holds a pending item.
    a_stall_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> q_full && !q_push)
        else $error("input stalled without a pending item");

endmodule

// ----- tb/lab_depth_neighbor_edge_map_unit_test.sv -----
// Self-checking testbench of the L*a*b*-depth neighbor edge map unit.
`timescale 1ns / 100ps

module lab_depth_neighbor_edge_map_unit_test;
    import ldnem_pkg::*;

    localparam int LINE_LEN     = DEF_MAX_WIDTH;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 600000;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PATTERN,
        STALL_RUNS
    } stall_mode_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_write;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic [CHAN_W-1:0]        lightness;
    logic [CHAN_W-1:0]        a_axis;
    logic [CHAN_W-1:0]        b_axis;
    logic [CHAN_W-1:0]        depth_value;
    logic                     frame_start;
    logic                     out_valid;
    logic                     out_stall;
    logic [CHAN_W-1:0]        edge_strength;

    // Shadow copy of the block's registers and pixel state.
    logic [IMAGE_WIDTH_W-1:0] cfg_width  = RST_IMAGE_WIDTH;
    logic [WEIGHT_W-1:0]      wt_l       = RST_WEIGHT_L;
    logic [WEIGHT_W-1:0]      wt_a       = RST_WEIGHT_A;
    logic [WEIGHT_W-1:0]      wt_b       = RST_WEIGHT_B;
    logic [WEIGHT_W-1:0]      wt_d       = RST_WEIGHT_D;
    logic [GAIN_W-1:0]        gain       = RST_GAIN;
    logic [BRIGHT_W-1:0]      bright     = RST_BRIGHTNESS;
    pixel_t                   line_mem [LINE_LEN];
    bit                       line_written [LINE_LEN];
    pixel_t                   left_pix   = '0;
    int                       col_pos    = 0;
    bit                       first_row  = 1'b1;

    logic [CHAN_W-1:0]        expected_edges [$];
    int                       mismatches  = 0;
    int                       cycle_count = 0;
    int                       burst_left  = 0;
    int                       gap_max     = 0;
    int                       hold_left   = 0;
    stall_mode_t              stall_mode  = STALL_NONE;
    int                       stall_run   = 0;
    bit                       stall_state = 1'b0;
    pixel_t                   last_pixel  = '0;

    lab_depth_neighbor_edge_map_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .lightness    (lightness),
        .a_axis       (a_axis),
        .b_axis       (b_axis),
        .depth_value  (depth_value),
        .frame_start  (frame_start),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .edge_strength(edge_strength)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic longint unsigned sq_gap(logic [CHAN_W-1:0] x, logic [CHAN_W-1:0] y);
        longint unsigned d;
        d = (x > y) ? 64'(x) - 64'(y) : 64'(y) - 64'(x);
        return d * d;
    endfunction

    function automatic int unsigned neighbor_distance(pixel_t p, pixel_t q);
        longint unsigned acc;
        longint unsigned v;
        int unsigned     root;
        int unsigned     trial;
        acc = 64'(wt_l) * sq_gap(p.l, q.l) + 64'(wt_a) * sq_gap(p.a, q.a)
            + 64'(wt_b) * sq_gap(p.b, q.b) + 64'(wt_d) * sq_gap(p.depth, q.depth);
        v = 64'(gain) * 64'(gain) * acc;
        if (v >= 64'd65536)
            return 255;
        root = 0;
        for (int bit_pos = 7; bit_pos >= 0; bit_pos--)
        begin
            trial = root | (32'd1 << bit_pos);
            if (64'(trial) * 64'(trial) <= v)
                root = trial;
        end
        return root;
    endfunction

    // Advances the shadow state by one pixel and returns its edge strength.
    function automatic logic [CHAN_W-1:0] predict_edge(pixel_t pix, logic fs);
        int              eff_w;
        int              col;
        int unsigned     best;
        int unsigned     dl;
        bit              have;
        longint unsigned res;
        eff_w = (cfg_width == 0) ? 1 : ((cfg_width > LINE_LEN) ? LINE_LEN : int'(cfg_width));
        if (fs)
        begin
            col_pos   = 0;
            first_row = 1'b1;
        end
        col  = col_pos % LINE_LEN;
        best = 0;
        have = 1'b0;
        if (!first_row)
        begin
            best = neighbor_distance(pix, line_mem[col]);
            have = 1'b1;
        end
        if (col_pos > 0)
        begin
            dl = neighbor_distance(pix, left_pix);
            if (!have || dl < best)
                best = dl;
            have = 1'b1;
        end
        res = have ? 64'(best) * 64'(bright) : 64'd0;
        if (res > 255)
            res = 255;
        line_mem[col]     = pix;
        line_written[col] = 1'b1;
        left_pix          = pix;
        col_pos++;
        if (col_pos >= eff_w)
        begin
            col_pos   = 0;
            first_row = 1'b0;
        end
        return res[CHAN_W-1:0];
    endfunction

    function automatic pixel_t px(int l, int a, int b, int d);
        pixel_t p;
        p.l     = l[7:0];
        p.a     = a[7:0];
        p.b     = b[7:0];
        p.depth = d[7:0];
        return p;
    endfunction

    function automatic pixel_t next_pixel(pixel_t prev);
        pixel_t p;
        case ($urandom_range(0, 5))
            0: p = pixel_t'($urandom);
            1: p = px($urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255,
                      $urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255);
            default:
            begin
                p.l     = prev.l + 8'($urandom_range(0, 6)) - 8'd3;
                p.a     = prev.a + 8'($urandom_range(0, 6)) - 8'd3;
                p.b     = prev.b + 8'($urandom_range(0, 6)) - 8'd3;
                p.depth = prev.depth + 8'($urandom_range(0, 6)) - 8'd3;
            end
        endcase
        return p;
    endfunction

    task automatic send_pixel(input pixel_t p, input logic fs);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        // A line entry that was never written must not be read; restart the frame instead.
        if (!fs && !first_row && !line_written[col_pos % LINE_LEN])
            fs = 1'b1;
        in_valid    <= 1'b1;
        lightness   <= p.l;
        a_axis      <= p.a;
        b_axis      <= p.b;
        depth_value <= p.depth;
        frame_start <= fs;
        do
            @(posedge clk);
        while (in_stall);
        expected_edges.push_back(predict_edge(p, fs));
        last_pixel = p;
    endtask

    task automatic send_stream(input int count, input bit open_frame);
        pixel_t p;
        logic   fs;
        for (int i = 0; i < count; i++)
        begin
            p  = next_pixel(last_pixel);
            fs = (i == 0) ? open_frame : ($urandom_range(0, 39) == 0);
            send_pixel(p, fs);
        end
    endtask

    task automatic wait_idle;
        in_valid <= 1'b0;
        while (expected_edges.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        case (idx)
            CFG_IMAGE_WIDTH: cfg_width = value[IMAGE_WIDTH_W-1:0];
            CFG_WEIGHT_L:    wt_l      = value[WEIGHT_W-1:0];
            CFG_WEIGHT_A:    wt_a      = value[WEIGHT_W-1:0];
            CFG_WEIGHT_B:    wt_b      = value[WEIGHT_W-1:0];
            CFG_WEIGHT_D:    wt_d      = value[WEIGHT_W-1:0];
            CFG_GAIN:        gain      = value[GAIN_W-1:0];
            CFG_BRIGHTNESS:  bright    = value[BRIGHT_W-1:0];
            default:         ;
        endcase
    endtask

    task automatic apply_settings(input int w, input int wl, input int wa, input int wb,
                                  input int wd, input int g, input int br);
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_WEIGHT_L, wl);
        write_reg(CFG_WEIGHT_A, wa);
        write_reg(CFG_WEIGHT_B, wb);
        write_reg(CFG_WEIGHT_D, wd);
        write_reg(CFG_GAIN, g);
        write_reg(CFG_BRIGHTNESS, br);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (stall_mode)
                    STALL_NONE:    out_stall <= 1'b0;
                    STALL_RANDOM:  out_stall <= ($urandom_range(0, 2) == 0);
                    STALL_PATTERN: out_stall <= ((cycle_count % 11) < 4);
                    default:
                    begin
                        if (stall_run == 0)
                        begin
                            stall_run   = $urandom_range(1, 12);
                            stall_state = !stall_state;
                        end
                        stall_run--;
                        out_stall <= stall_state;
                    end
                endcase
            end
        end
    end

    initial
    begin
        logic [CHAN_W-1:0] want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_edges.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("edge_strength %0d arrived with no item pending", edge_strength);
                end
                else
                begin
                    want = expected_edges.pop_front();
                    if (edge_strength !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("edge_strength mismatch: expected %0d, got %0d",
                                     want, edge_strength);
                    end
                end
            end
        end
    end

    task automatic test_reset_state;
        gap_max    = 3;
        stall_mode = STALL_RANDOM;
        send_pixel(px(0, 0, 0, 0), 1'b0);
        send_pixel(px(255, 255, 255, 255), 1'b0);
        send_pixel(px(255, 0, 0, 0), 1'b0);
        send_pixel(px(0, 0, 0, 255), 1'b0);
        send_pixel(px(1, 0, 0, 255), 1'b0);
    endtask

    task automatic test_extreme_settings;
        apply_settings(2, 15, 15, 15, 15, 31, 255);
        send_pixel(px(0, 0, 0, 0), 1'b1);
        send_pixel(px(255, 255, 255, 255), 1'b0);
        send_pixel(px(255, 255, 255, 255), 1'b0);
        send_pixel(px(0, 0, 0, 0), 1'b0);
        send_pixel(px(0, 255, 0, 255), 1'b0);
        send_pixel(px(255, 0, 255, 0), 1'b1);
        apply_settings(2, 0, 0, 0, 0, 0, 0);
        send_pixel(px(0, 0, 0, 0), 1'b1);
        send_pixel(px(255, 255, 255, 255), 1'b0);
    endtask

    task automatic test_single_column;
        apply_settings(0, 1, 1, 1, 1, 1, 1);
        send_pixel(px(10, 20, 30, 40), 1'b1);
        send_pixel(px(13, 24, 30, 40), 1'b0);
        send_pixel(px(13, 24, 42, 40), 1'b0);
        send_pixel(px(13, 24, 42, 39), 1'b0);
    endtask

    task automatic test_width_shrink;
        stall_mode = STALL_PATTERN;
        apply_settings(4, 1, 1, 1, 1, 1, 1);
        send_stream(7, 1'b1);
        apply_settings(2, 3, 5, 7, 9, 2, 3);
        send_stream(3, 1'b0);
    endtask

    task automatic test_full_width_row;
        gap_max    = 0;
        stall_mode = STALL_NONE;
        apply_settings(2047, 2, 3, 1, 4, 1, 2);
        send_stream(LINE_LEN + 8, 1'b1);
    endtask

    task automatic test_output_hold_off;
        apply_settings(16, 1, 2, 3, 4, 2, 1);
        gap_max    = 0;
        stall_mode = STALL_NONE;
        hold_left  = 300;
        send_stream(40, 1'b1);
    endtask

    task automatic test_random_settings;
        int w;
        for (int phase = 0; phase < 6; phase++)
        begin
            case ($urandom_range(0, 9))
                0:       w = $urandom_range(0, 1);
                1:       w = $urandom_range(LINE_LEN, 2047);
                2:       w = $urandom_range(17, 200);
                default: w = $urandom_range(2, 16);
            endcase
            apply_settings(w, $urandom_range(0, 15), $urandom_range(0, 15),
                           $urandom_range(0, 15), $urandom_range(0, 15),
                           $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 31),
                           $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(0, 255));
            gap_max    = $urandom_range(0, 2) * 4;
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            send_stream(10, $urandom_range(0, 1));
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        cfg_write   <= 1'b0;
        cfg_index   <= CFG_IMAGE_WIDTH;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        lightness   <= '0;
        a_axis      <= '0;
        b_axis      <= '0;
        depth_value <= '0;
        frame_start <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_extreme_settings();
        test_single_column();
        test_width_shrink();
        test_full_width_row();
        test_output_hold_off();
        test_random_settings();

        wait_idle();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
design/ldnem_pkg.sv
design/ldnem_front.sv
design/ldnem_queue.sv
design/ldnem_back.sv
design/lab_depth_neighbor_edge_map_unit.sv
tb/lab_depth_neighbor_edge_map_unit_test.sv
